[src/z80nt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80nt_pkg: types, opcode constants and timing decode functions
// Shared by the Z80 NOP timing pipeline and its group decoder.
// ----------------------------------------------------------------------------
package z80nt_pkg;

	// prefixes and opcodes with timing of their own
	localparam logic [7:0] OP_PFX_CB = 8'hcb;
	localparam logic [7:0] OP_PFX_DD = 8'hdd;
	localparam logic [7:0] OP_PFX_ED = 8'hed;
	localparam logic [7:0] OP_PFX_FD = 8'hfd;
	localparam logic [7:0] OP_HALT   = 8'h76;
	localparam logic [7:0] OP_DJNZ   = 8'h10;
	localparam logic [7:0] OP_JR     = 8'h18;
	localparam logic [7:0] OP_RET    = 8'hc9;
	localparam logic [7:0] OP_JP     = 8'hc3;
	localparam logic [7:0] OP_EX_SP  = 8'he3;
	localparam logic [7:0] OP_JP_HL  = 8'he9;
	localparam logic [7:0] OP_LD_SP  = 8'hf9;

	// ED block-transfer group
	localparam logic [7:0] ED_BLK_MASK = 8'he4;
	localparam logic [7:0] ED_BLK_CODE = 8'ha0;
	localparam logic [7:0] ED_ONCE_MASK = 8'hf4;

	// opcode quadrant (bits 7:6) and the (HL) register field code
	localparam logic [1:0] QD_MISC = 2'b00;
	localparam logic [1:0] QD_LD   = 2'b01;
	localparam logic [1:0] QD_ALU  = 2'b10;
	localparam logic [1:0] QD_CTRL = 2'b11;
	localparam logic [2:0] REG_HL  = 3'd6;

	typedef enum logic [1:0] {
		GRP_MAIN = 2'd0,
		GRP_CB   = 2'd1,
		GRP_ED   = 2'd2,
		GRP_IDX  = 2'd3
	} grp_t;

	typedef struct packed {
		logic       known;
		logic [2:0] cnt;
	} tm_t;

	typedef struct packed {
		tm_t t_main;
		tm_t t_cb;
		tm_t t_ed;
		tm_t t_idx;
	} grp_times_t;

	localparam tm_t TM_UNKNOWN = '0;

	function automatic tm_t tm(input logic [2:0] c);
		tm_t r;
		r.known = 1'b1;
		r.cnt   = c;
		return r;
	endfunction

	function automatic tm_t time_cb(input logic [7:0] op);
		tm_t r;
		if (op[2:0] != REG_HL)
			r = tm(3'd2);
		else if (op[7:6] == QD_LD)
			r = tm(3'd3);
		else
			r = tm(3'd4);
		return r;
	endfunction

	function automatic tm_t time_ed(input logic [7:0] op);
		tm_t r;
		if (op[7:6] == QD_LD) begin
			unique case (op[2:0]) inside
				3'd0, 3'd1, 3'd2, 3'd5: r = tm(3'd4);
				3'd3: r = tm(3'd6);
				3'd4, 3'd6: r = tm(3'd2);
				default: begin
					if (!op[5])
						r = tm(3'd3);
					else if (!op[4])
						r = tm(3'd5);
					else
						r = tm(3'd2);
				end
			endcase
		end else if ((op & ED_BLK_MASK) == ED_BLK_CODE) begin
			// single-shot block ops are fixed, repeating ones are not
			r = ((op & ED_ONCE_MASK) == ED_BLK_CODE) ? tm(3'd5) : TM_UNKNOWN;
		end else begin
			r = tm(3'd2);
		end
		return r;
	endfunction

	function automatic tm_t time_index(input logic [7:0] op, input logic [7:0] cbop);
		tm_t        r;
		logic [2:0] hi;
		logic [2:0] lo;
		hi = op[5:3];
		lo = op[2:0];
		r  = TM_UNKNOWN;
		if (op == OP_PFX_DD || op == OP_PFX_FD || op == OP_PFX_ED) begin
			r = tm(3'd1);
		end else if (op == OP_PFX_CB) begin
			r = (cbop[7:6] == QD_LD) ? tm(3'd6) : tm(3'd7);
		end else begin
			unique case (op[7:6])
				QD_MISC: begin
					unique case (lo) inside
						3'd1: r = tm(3'd4);
						3'd2: r = (op[5:4] == 2'd2) ? tm(3'd6) : TM_UNKNOWN;
						3'd3: r = tm(3'd3);
						3'd4, 3'd5: r = (hi == REG_HL) ? tm(3'd6) : tm(3'd2);
						3'd6: r = (hi == REG_HL) ? tm(3'd6) : tm(3'd3);
						default: r = TM_UNKNOWN;
					endcase
				end
				QD_LD: r = (hi == REG_HL || lo == REG_HL) ? tm(3'd5) : tm(3'd2);
				QD_ALU: r = (lo == REG_HL) ? tm(3'd5) : tm(3'd2);
				default: begin
					unique case (lo) inside
						3'd1: begin
							if (!op[3])
								r = tm(3'd4);
							else if (op == OP_JP_HL)
								r = tm(3'd2);
							else if (op == OP_LD_SP)
								r = tm(3'd3);
							else
								r = TM_UNKNOWN;
						end
						3'd3: r = (op == OP_EX_SP) ? tm(3'd7) : TM_UNKNOWN;
						3'd5: r = (!op[3]) ? tm(3'd5) : TM_UNKNOWN;
						default: r = TM_UNKNOWN;
					endcase
				end
			endcase
		end
		return r;
	endfunction

	function automatic tm_t time_main(input logic [7:0] op);
		tm_t        r;
		logic [2:0] hi;
		logic [2:0] lo;
		hi = op[5:3];
		lo = op[2:0];
		r  = TM_UNKNOWN;
		unique case (op[7:6])
			QD_MISC: begin
				unique case (lo) inside
					3'd0: begin
						// JR cc and DJNZ depend on the outcome
						if (op[5] || op == OP_DJNZ)
							r = TM_UNKNOWN;
						else if (op == OP_JR)
							r = tm(3'd3);
						else
							r = tm(3'd1);
					end
					3'd1: r = tm(3'd3);
					3'd2: begin
						unique case (op[5:4]) inside
							2'd0, 2'd1: r = tm(3'd2);
							2'd2: r = tm(3'd5);
							default: r = tm(3'd4);
						endcase
					end
					3'd3: r = tm(3'd2);
					3'd4, 3'd5: r = (hi == REG_HL) ? tm(3'd3) : tm(3'd1);
					3'd6: r = tm(3'd2);
					default: r = tm(3'd1);
				endcase
			end
			QD_LD: begin
				if (op == OP_HALT)
					r = tm(3'd1);
				else
					r = (hi == REG_HL || lo == REG_HL) ? tm(3'd2) : tm(3'd1);
			end
			QD_ALU: r = (lo == REG_HL) ? tm(3'd2) : tm(3'd1);
			default: begin
				unique case (lo) inside
					3'd0, 3'd4: r = TM_UNKNOWN;
					3'd1: begin
						if (!op[3] || op == OP_RET)
							r = tm(3'd3);
						else if (op == OP_LD_SP)
							r = tm(3'd2);
						else
							r = tm(3'd1);
					end
					3'd2: r = tm(3'd3);
					3'd3: begin
						if (op[5:4] == 2'b01 || op == OP_JP)
							r = tm(3'd3);
						else if (op == OP_EX_SP)
							r = tm(3'd6);
						else
							r = tm(3'd1);
					end
					3'd5: r = (!op[3]) ? tm(3'd4) : tm(3'd5);
					3'd6: r = tm(3'd2);
					default: r = tm(3'd4);
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

[src/z80nt_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80nt_decode: per-group timing decode
// Works out the timing of the selected opcode under all four opcode groups
// at once; the pipeline picks the right one a stage later.
// ----------------------------------------------------------------------------
module z80nt_decode
	import z80nt_pkg::*;
(
	input  logic [7:0] op,
	input  logic [7:0] cbop,
	output grp_times_t times
);

	always_comb begin
		times.t_main = time_main(op);
		times.t_cb   = time_cb(op);
		times.t_ed   = time_ed(op);
		times.t_idx  = time_index(op, cbop);
	end

endmodule

[src/z80_instruction_nop_timing_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80_instruction_nop_timing_core: Z80 instruction duration in NOP units
// Three-stage pipeline: prefix classify, group decode, select.
// ----------------------------------------------------------------------------
// Takes the leading bytes of one Z80 instruction per transfer and returns its
// duration in NOP units, with known low (and a count of 0) for instructions
// whose timing depends on the outcome or that have no timing entry. One
// instruction is taken every cycle while instr_stall is low; its result is
// registered in turn in each stage (prefix classify, group decode, select).
// Bubbles are squeezed out while the output is stalled, so instr_stall rises
// only when all three stages hold an item. byte_two is the DD/FD CB
// displacement and plays no part in the timing.
module z80_instruction_nop_timing_core
	import z80nt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       instr_valid,
	output logic       instr_stall,
	input  logic [7:0] byte_zero,
	input  logic [7:0] byte_one,
	input  logic [7:0] byte_two,
	input  logic [7:0] byte_three,
	output logic       timing_valid,
	input  logic       timing_stall,
	output logic [2:0] nop_count,
	output logic       known
);

	logic       valid_s1, valid_s2, valid_s3;
	logic       en1, en2, en3;
	grp_t       grp_s1, grp_s2;
	logic [7:0] op_s1, cbop_s1;
	grp_times_t times_d, times_s2;
	tm_t        sel_d, tm_s3;
	grp_t       grp_d;
	logic [7:0] op_d;

	// a stage moves when it is empty or the one after it moves
	assign en3 = !valid_s3 || !timing_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign instr_stall = !en1;

	// stage 1: prefix classify
	always_comb begin
		if (byte_zero == OP_PFX_CB)
			grp_d = GRP_CB;
		else if (byte_zero == OP_PFX_ED)
			grp_d = GRP_ED;
		else if (byte_zero == OP_PFX_DD || byte_zero == OP_PFX_FD)
			grp_d = GRP_IDX;
		else
			grp_d = GRP_MAIN;
		op_d = (grp_d == GRP_MAIN) ? byte_zero : byte_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && instr_valid) begin
			grp_s1  <= grp_d;
			op_s1   <= op_d;
			cbop_s1 <= byte_three;
		end
	end

	// stage 2: group decode
	z80nt_decode u_decode (
		.op    (op_s1),
		.cbop  (cbop_s1),
		.times (times_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			grp_s2   <= grp_s1;
			times_s2 <= times_d;
		end
	end

	// stage 3: select
	always_comb begin
		unique case (grp_s2)
			GRP_CB:  sel_d = times_s2.t_cb;
			GRP_ED:  sel_d = times_s2.t_ed;
			GRP_IDX: sel_d = times_s2.t_idx;
			default: sel_d = times_s2.t_main;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			tm_s3 <= sel_d;
		end
	end

	assign timing_valid = valid_s3;
	assign nop_count    = tm_s3.cnt;
	assign known        = tm_s3.known;

`ifndef NO_ASSERTIONS
	// unknown timing always reports a zero count
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !tm_s3.known) |-> (tm_s3.cnt == 3'd0))
		else $error("unknown timing with non-zero count");

	// every fixed timing lasts at least one NOP
	a_known_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && tm_s3.known) |-> (tm_s3.cnt != 3'd0))
		else $error("known timing with zero count");

	// input held off only with every stage full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		instr_stall |-> (valid_s1 && valid_s2 && valid_s3 && timing_stall))
		else $error("input stalled with a free stage");

	// CB group timing is always fixed
	a_cb_known: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && grp_s2 == GRP_CB) |-> times_s2.t_cb.known)
		else $error("CB opcode decoded as unknown");
`endif

endmodule

[tb/z80nt_timing_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80nt_timing_monitor: expected-duration tracker for the NOP timing core
// Watches both channels, works out each instruction's duration from its
// bytes and compares it with the result that comes back, in order.
// ----------------------------------------------------------------------------
module z80nt_timing_monitor
	import z80nt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       instr_valid,
	input  logic       instr_stall,
	input  logic [7:0] byte_zero,
	input  logic [7:0] byte_one,
	input  logic [7:0] byte_two,
	input  logic [7:0] byte_three,
	input  logic       timing_valid,
	input  logic       timing_stall,
	input  logic [2:0] nop_count,
	input  logic       known,
	output int         mismatches,
	output int         in_flight,
	output int         results_seen,
	output int         unknown_seen
);

	localparam int NO_FIXED_TIME = -1;

	typedef struct packed {
		logic       known;
		logic [2:0] count;
	} nop_time_t;

	nop_time_t expected_times[$];

	function automatic int nops_bit_group(input logic [7:0] op);
		if (op[2:0] != REG_HL)
			return 2;
		return (op[7:6] == QD_LD) ? 3 : 4;
	endfunction

	function automatic int nops_ed_group(input logic [7:0] op);
		if (op[7:6] == QD_LD) begin
			case (op[2:0])
				3'd3: return 6;
				3'd4, REG_HL: return 2;
				3'd7: return op[5] ? (op[4] ? 2 : 5) : 3;
				default: return 4;
			endcase
		end
		// block transfer group: the repeating forms have no fixed time
		if (op[7:5] == 3'b101 && !op[2])
			return op[4] ? NO_FIXED_TIME : 5;
		return 2;
	endfunction

	function automatic int nops_index_group(input logic [7:0] op, input logic [7:0] cb_op);
		logic [2:0] hi;
		logic [2:0] lo;
		hi = op[5:3];
		lo = op[2:0];
		if (op == OP_PFX_DD || op == OP_PFX_FD || op == OP_PFX_ED)
			return 1;
		// displacement byte is skipped, only the trailing opcode counts
		if (op == OP_PFX_CB)
			return (cb_op[7:6] == QD_LD) ? 6 : 7;
		case (op[7:6])
			QD_MISC: begin
				case (lo)
					3'd1: return 4;
					3'd2: return (op[5:4] == 2'd2) ? 6 : NO_FIXED_TIME;
					3'd3: return 3;
					3'd4, 3'd5: return (hi == REG_HL) ? 6 : 2;
					REG_HL: return (hi == REG_HL) ? 6 : 3;
					default: return NO_FIXED_TIME;
				endcase
			end
			QD_LD: return (hi == REG_HL || lo == REG_HL) ? 5 : 2;
			QD_ALU: return (lo == REG_HL) ? 5 : 2;
			default: begin
				if (op == OP_EX_SP)
					return 7;
				if (op == OP_JP_HL)
					return 2;
				if (op == OP_LD_SP)
					return 3;
				if (!op[3] && lo == 3'd1)
					return 4;
				if (!op[3] && lo == 3'd5)
					return 5;
				return NO_FIXED_TIME;
			end
		endcase
		return NO_FIXED_TIME;
	endfunction

	function automatic int nops_plain(input logic [7:0] op);
		logic [2:0] hi;
		logic [2:0] lo;
		hi = op[5:3];
		lo = op[2:0];
		if (op == OP_HALT)
			return 1;
		case (op[7:6])
			QD_MISC: begin
				case (lo)
					3'd0: begin
						if (op[5] || op == OP_DJNZ)
							return NO_FIXED_TIME;
						return (op == OP_JR) ? 3 : 1;
					end
					3'd2: begin
						if (op[5:4] == 2'd2)
							return 5;
						return (op[5:4] == 2'd3) ? 4 : 2;
					end
					3'd4, 3'd5: return (hi == REG_HL) ? 3 : 1;
					3'd7: return 1;
					default: return (lo == 3'd1) ? 3 : 2;
				endcase
			end
			QD_LD: return (hi == REG_HL || lo == REG_HL) ? 2 : 1;
			QD_ALU: return (lo == REG_HL) ? 2 : 1;
			default: begin
				case (lo)
					3'd0, 3'd4: return NO_FIXED_TIME;
					3'd1: begin
						if (!op[3] || op == OP_RET)
							return 3;
						return (op == OP_LD_SP) ? 2 : 1;
					end
					3'd2: return 3;
					3'd3: begin
						if (op == OP_EX_SP)
							return 6;
						return (op == OP_JP || op[5:4] == 2'b01) ? 3 : 1;
					end
					3'd5: return op[3] ? 5 : 4;
					REG_HL: return 2;
					default: return 4;
				endcase
			end
		endcase
		return NO_FIXED_TIME;
	endfunction

	function automatic nop_time_t instr_duration(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b3);
		int        t;
		nop_time_t d;
		if (b0 == OP_PFX_CB)
			t = nops_bit_group(b1);
		else if (b0 == OP_PFX_ED)
			t = nops_ed_group(b1);
		else if (b0 == OP_PFX_DD || b0 == OP_PFX_FD)
			t = nops_index_group(b1, b3);
		else
			t = nops_plain(b0);
		d.known = (t >= 0);
		d.count = (t >= 0) ? t[2:0] : 3'd0;
		return d;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s after %0d results: got %0d, want %0d",
			$realtime, what, results_seen, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		nop_time_t want;
		if (arst_n) begin
			if (timing_valid && !timing_stall) begin
				results_seen++;
				if (!known)
					unknown_seen++;
				if (expected_times.size() == 0) begin
					flag_mismatch("unexpected result transfer", int'(nop_count), -1);
				end else begin
					want = expected_times.pop_front();
					if (known !== want.known)
						flag_mismatch("known", int'(known), int'(want.known));
					if (nop_count !== want.count)
						flag_mismatch("nop_count", int'(nop_count), int'(want.count));
				end
			end
			if (instr_valid && !instr_stall)
				expected_times.push_back(instr_duration(byte_zero, byte_one, byte_three));
			in_flight = expected_times.size();
		end
	end

endmodule

[tb/z80_instruction_nop_timing_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80_instruction_nop_timing_core_test: top-level bench for the NOP timing core
// Directed opcodes from every group, then random instructions with random
// gaps and output stalls; a monitor checks every duration in order.
// ----------------------------------------------------------------------------
module z80_instruction_nop_timing_core_test
	import z80nt_pkg::*;
;

	localparam int RANDOM_INSTRS = 1825;
	localparam int CALM_TAIL     = 150;
	localparam int LONG_HOLD     = 40;
	localparam int DRAIN_CYCLES  = 10;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       instr_valid  = 1'b0;
	logic [7:0] byte_zero    = 8'h00;
	logic [7:0] byte_one     = 8'h00;
	logic [7:0] byte_two     = 8'h00;
	logic [7:0] byte_three   = 8'h00;
	logic       timing_stall = 1'b0;
	logic       instr_stall;
	logic       timing_valid;
	logic [2:0] nop_count;
	logic       known;

	int mismatches;
	int in_flight;
	int results_seen;
	int unknown_seen;
	int instrs_sent;
	bit calm;
	bit hold_request;
	int long_holds;

	z80_instruction_nop_timing_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.byte_zero    (byte_zero),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.timing_valid (timing_valid),
		.timing_stall (timing_stall),
		.nop_count    (nop_count),
		.known        (known)
	);

	z80nt_timing_monitor monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.byte_zero    (byte_zero),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.timing_valid (timing_valid),
		.timing_stall (timing_stall),
		.nop_count    (nop_count),
		.known        (known),
		.mismatches   (mismatches),
		.in_flight    (in_flight),
		.results_seen (results_seen),
		.unknown_seen (unknown_seen)
	);

	always #6 clk = ~clk;

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_instr(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		if (!calm && $urandom_range(0, 4) == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		instr_valid <= 1'b1;
		byte_zero   <= b0;
		byte_one    <= b1;
		byte_two    <= b2;
		byte_three  <= b3;
		@(negedge clk);
		while (instr_stall)
			@(negedge clk);
		@(posedge clk);
		instrs_sent++;
	endtask

	task automatic send_random_instr();
		logic [7:0] b0;
		logic [7:0] b1;
		int         pick;
		pick = $urandom_range(0, 99);
		b1   = 8'($urandom_range(0, 255));
		if (pick < 25) begin
			b0 = 8'($urandom_range(0, 255));
		end else if (pick < 45) begin
			b0 = OP_PFX_CB;
		end else if (pick < 65) begin
			b0 = OP_PFX_ED;
		end else begin
			b0 = $urandom_range(0, 1) ? OP_PFX_DD : OP_PFX_FD;
			if ($urandom_range(0, 3) == 0)
				b1 = OP_PFX_CB;
		end
		send_instr(b0, b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// output side: short random stalls, one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				timing_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				long_holds++;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				timing_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				timing_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		#6000000;
		$display("timeout with %0d results outstanding", in_flight);
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain opcodes: NOP, RST, DJNZ, JR cc, HALT, EX (SP),HL, CALL cc, CALL
		send_instr(8'h00, 8'hff, 8'hff, 8'hff);
		send_instr(8'hff, 8'h00, 8'h00, 8'h00);
		send_instr(OP_DJNZ, 8'hff, 8'h00, 8'hff);
		send_instr(8'h38, 8'h00, 8'hff, 8'h00);
		send_instr(OP_HALT, 8'h00, 8'h00, 8'h00);
		send_instr(OP_EX_SP, 8'hff, 8'hff, 8'hff);
		send_instr(8'hc4, 8'h00, 8'h00, 8'h00);
		send_instr(8'hcd, 8'hff, 8'hff, 8'hff);
		// bit group: register, BIT (HL), SET (HL)
		send_instr(OP_PFX_CB, 8'h00, 8'hff, 8'hff);
		send_instr(OP_PFX_CB, 8'h46, 8'h00, 8'h00);
		send_instr(OP_PFX_CB, 8'hfe, 8'hff, 8'h00);
		// ED group: 40-7F block, single and repeating transfers, undefined ends
		send_instr(OP_PFX_ED, 8'h43, 8'h00, 8'hff);
		send_instr(OP_PFX_ED, 8'h6f, 8'hff, 8'h00);
		send_instr(OP_PFX_ED, 8'ha0, 8'h00, 8'h00);
		send_instr(OP_PFX_ED, 8'hb0, 8'hff, 8'hff);
		send_instr(OP_PFX_ED, 8'h00, 8'h00, 8'h00);
		send_instr(OP_PFX_ED, 8'hff, 8'hff, 8'hff);
		// index group: double prefixes, indexed bit ops, LD r,(IX+d) form, EX (SP),IY, misses
		send_instr(OP_PFX_DD, OP_PFX_DD, 8'h00, 8'h00);
		send_instr(OP_PFX_FD, OP_PFX_ED, 8'hff, 8'hff);
		send_instr(OP_PFX_DD, OP_PFX_CB, 8'hff, 8'h46);
		send_instr(OP_PFX_FD, OP_PFX_CB, 8'h80, 8'hff);
		send_instr(OP_PFX_DD, OP_HALT, 8'h00, 8'h00);
		send_instr(OP_PFX_FD, OP_EX_SP, 8'hff, 8'hff);
		send_instr(OP_PFX_DD, 8'h00, 8'h00, 8'h00);
		send_instr(OP_PFX_FD, 8'hff, 8'hff, 8'hff);

		// keep offering while the output is held so the pipeline backs up
		hold_request = 1'b1;
		for (int n = 0; n < RANDOM_INSTRS; n++) begin
			if (n == RANDOM_INSTRS - CALM_TAIL)
				calm = 1'b1;
			send_random_instr();
		end
		instr_valid <= 1'b0;

		@(negedge clk);
		while (in_flight != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d instructions across all opcode groups, %0d results checked",
			instrs_sent, results_seen);
		$display("%0d without fixed timing; %0d long output hold-off(s)",
			unknown_seen, long_holds);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
